// ----- sv/wiper_washer_controller_top_assert.svh -----
`ifndef WIPER_WASHER_CONTROLLER_TOP_ASSERT_SVH
`define WIPER_WASHER_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define WWC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wiper washer controller: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define WWC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wiper washer controller: next-cycle check failed");

`endif

// ----- sv/wwc_pkg.sv -----
package wwc_pkg;

   // register map, word index = paddr[4:2]
   localparam int unsigned CSR_ADDR_W = 5;
   localparam logic [2:0] CSR_DEBOUNCE     = 3'd0;
   localparam logic [2:0] CSR_WASH_START   = 3'd1;
   localparam logic [2:0] CSR_WASH_STOP    = 3'd2;
   localparam logic [2:0] CSR_SWEEP        = 3'd3;
   localparam logic [2:0] CSR_PERIOD_SHORT = 3'd4;
   localparam logic [2:0] CSR_PERIOD_MID   = 3'd5;
   localparam logic [2:0] CSR_PERIOD_LONG  = 3'd6;
   localparam logic [2:0] CSR_RAIN_CONFIRM = 3'd7;

   localparam logic [3:0]  RST_DEBOUNCE     = 4'd2;
   localparam logic [7:0]  RST_WASH_START   = 8'd15;
   localparam logic [9:0]  RST_WASH_STOP    = 10'd120;
   localparam logic [10:0] RST_SWEEP        = 11'd40;
   localparam logic [11:0] RST_PERIOD_SHORT = 12'd140;
   localparam logic [11:0] RST_PERIOD_MID   = 12'd540;
   localparam logic [11:0] RST_PERIOD_LONG  = 12'd1040;
   localparam logic [7:0]  RST_RAIN_CONFIRM = 8'd5;

   // delay knob voltage bands (mV)
   localparam logic [12:0] BAND_LOW_MV = 13'd1666;
   localparam logic [12:0] BAND_MID_MV = 13'd3333;

   // rain sensor settling
   localparam logic [5:0] SETTLE_LIMIT = 6'd10;
   localparam logic [5:0] SETTLE_HOLD  = 6'd50;

   // switch bit positions
   localparam int unsigned SW_INT  = 0;
   localparam int unsigned SW_LOW  = 1;
   localparam int unsigned SW_HIGH = 2;
   localparam int unsigned SW_WASH = 3;

   typedef struct packed {
      logic        sw_intermittent;
      logic        sw_low;
      logic        sw_high;
      logic        sw_washer;
      logic        park_switch;
      logic        ignition;
      logic        charge_door;
      logic [12:0] delay_mv;
      logic        remote_off;
      logic        rain_low;
      logic        rain_high;
   } req_type;

   typedef struct packed {
      logic low_drive;
      logic high_drive;
      logic washer_drive;
      logic cluster_ign;
      logic sensor_power;
      logic rain_power;
      logic rain_park_signal;
      logic stat_intermittent;
      logic stat_low;
      logic stat_high;
      logic stat_washer;
      logic auto_active;
   } rsp_type;

endpackage

// ----- sv/wiper_washer_controller_top.sv -----
// Wiper and washer controller. Each req transaction is one control tick: raw
// switches, park contact, ignition, charge door, delay knob voltage, remote
// off and rain sensor outputs. Every tick yields exactly one rsp transaction
// carrying the latched motor/washer/sensor pins and status bits. One tick is
// taken per clock while req_stall is low; the whole tick is evaluated in one
// combinational pass over the state registers and registered into the result
// register, or into the one-entry skid buffer behind it when full and stalled;
// req_stall only rises when both are full (result stalled two ticks deep).
// Configuration is through an APB-style port, registers at byte address 4*i,
// and must only be written while no tick is in flight.

`include "wiper_washer_controller_top_assert.svh"

module wiper_washer_controller_top (
   input  logic                                   clock,
   input  logic                                   reset,
   // tick input
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  wwc_pkg::req_type                       req_data,
   // result output
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output wwc_pkg::rsp_type                       rsp_data,
   // configuration
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [wwc_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [31:0]                            pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);
   import wwc_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [3:0]  cfg_debounce_ff;
   logic [7:0]  cfg_wash_start_ff;
   logic [9:0]  cfg_wash_stop_ff;
   logic [10:0] cfg_sweep_ff;
   logic [11:0] cfg_period_short_ff;
   logic [11:0] cfg_period_mid_ff;
   logic [11:0] cfg_period_long_ff;
   logic [7:0]  cfg_rain_confirm_ff;

   logic       csr_write;
   logic [2:0] csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_debounce_ff     <= RST_DEBOUNCE;
         cfg_wash_start_ff   <= RST_WASH_START;
         cfg_wash_stop_ff    <= RST_WASH_STOP;
         cfg_sweep_ff        <= RST_SWEEP;
         cfg_period_short_ff <= RST_PERIOD_SHORT;
         cfg_period_mid_ff   <= RST_PERIOD_MID;
         cfg_period_long_ff  <= RST_PERIOD_LONG;
         cfg_rain_confirm_ff <= RST_RAIN_CONFIRM;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DEBOUNCE:     cfg_debounce_ff     <= pwdata[3:0];
            CSR_WASH_START:   cfg_wash_start_ff   <= pwdata[7:0];
            CSR_WASH_STOP:    cfg_wash_stop_ff    <= pwdata[9:0];
            CSR_SWEEP:        cfg_sweep_ff        <= pwdata[10:0];
            CSR_PERIOD_SHORT: cfg_period_short_ff <= pwdata[11:0];
            CSR_PERIOD_MID:   cfg_period_mid_ff   <= pwdata[11:0];
            CSR_PERIOD_LONG:  cfg_period_long_ff  <= pwdata[11:0];
            CSR_RAIN_CONFIRM: cfg_rain_confirm_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_DEBOUNCE:     prdata = {28'd0, cfg_debounce_ff};
         CSR_WASH_START:   prdata = {24'd0, cfg_wash_start_ff};
         CSR_WASH_STOP:    prdata = {22'd0, cfg_wash_stop_ff};
         CSR_SWEEP:        prdata = {21'd0, cfg_sweep_ff};
         CSR_PERIOD_SHORT: prdata = {20'd0, cfg_period_short_ff};
         CSR_PERIOD_MID:   prdata = {20'd0, cfg_period_mid_ff};
         CSR_PERIOD_LONG:  prdata = {20'd0, cfg_period_long_ff};
         CSR_RAIN_CONFIRM: prdata = {24'd0, cfg_rain_confirm_ff};
         default:          prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Tick state
   // ---------------------------------------------------------------------
   logic [3:0] db_ff,       db_in;        // debounced switches
   logic [3:0] prev_raw_ff, prev_raw_in;
   logic [3:0] db_cnt_ff [4];
   logic [3:0] db_cnt_in [4];
   logic       wash_prev_ff, wash_prev_in;
   logic       wash_on_ff,   wash_on_in;  // start delay armed
   logic       wash_off_ff,  wash_off_in; // stop delay armed
   logic [7:0] won_cnt_ff,  won_cnt_in;
   logic [9:0] woff_cnt_ff, woff_cnt_in;
   logic [11:0] sweep_ff,   sweep_in;
   logic       p_low_ff,  p_low_in;
   logic       p_high_ff, p_high_in;
   logic       p_wash_ff, p_wash_in;
   logic       p_sens_ff, p_sens_in;
   logic       p_rain_ff, p_rain_in;
   logic       p_park_ff, p_park_in;
   logic       s_int_ff,  s_int_in;
   logic       s_low_ff,  s_low_in;
   logic       s_high_ff, s_high_in;
   logic       s_wash_ff, s_wash_in;
   logic       s_auto_ff, s_auto_in;
   logic [5:0] settle_ff, settle_in;
   logic [7:0] rain_cnt_ff [2];
   logic [7:0] rain_cnt_in [2];
   logic [1:0] rain_act_ff, rain_act_in;

   logic [3:0]  raw;
   logic        washer;
   logic [11:0] period;
   logic [1:0]  rain_req;
   rsp_type     result;

   assign raw      = {req_data.sw_washer, req_data.sw_high, req_data.sw_low,
                      req_data.sw_intermittent};
   assign rain_req = {req_data.rain_high, req_data.rain_low};
   assign period   = (req_data.delay_mv < BAND_LOW_MV) ? cfg_period_short_ff :
                     (req_data.delay_mv < BAND_MID_MV) ? cfg_period_mid_ff :
                                                         cfg_period_long_ff;

   always_comb begin
      db_in        = db_ff;
      prev_raw_in  = raw;
      db_cnt_in    = db_cnt_ff;
      wash_prev_in = wash_prev_ff;
      wash_on_in   = wash_on_ff;
      wash_off_in  = wash_off_ff;
      won_cnt_in   = won_cnt_ff;
      woff_cnt_in  = woff_cnt_ff;
      sweep_in     = sweep_ff;
      p_low_in     = p_low_ff;
      p_high_in    = p_high_ff;
      p_wash_in    = p_wash_ff;
      p_sens_in    = p_sens_ff;
      p_rain_in    = p_rain_ff;
      p_park_in    = p_park_ff;
      s_int_in     = s_int_ff;
      s_low_in     = s_low_ff;
      s_high_in    = s_high_ff;
      s_wash_in    = s_wash_ff;
      s_auto_in    = s_auto_ff;
      settle_in    = settle_ff;
      rain_cnt_in  = rain_cnt_ff;
      rain_act_in  = rain_act_ff;

      // debounce, four independent channels
      for (int i = 0; i < 4; i++) begin
         if (prev_raw_ff[i] == raw[i]) begin
            db_cnt_in[i] = (db_cnt_ff[i] == 4'd15) ? 4'd15 : db_cnt_ff[i] + 4'd1;
            if (db_cnt_in[i] >= cfg_debounce_ff) db_in[i] = raw[i];
         end else begin
            db_cnt_in[i] = 4'd0;
         end
      end
      washer = db_in[SW_WASH];

      // washer follow-on wipe
      if (!wash_prev_ff && washer) begin
         won_cnt_in  = 8'd0;
         wash_off_in = 1'b0;
         wash_on_in  = 1'b1;
      end else if (wash_prev_ff && !washer) begin
         woff_cnt_in = 10'd0;
         wash_on_in  = 1'b0;
         wash_off_in = 1'b1;
      end
      if (wash_on_in) begin
         if (washer) begin
            if (won_cnt_in >= cfg_wash_start_ff) begin
               p_low_in    = 1'b1;
               wash_on_in  = 1'b0;
               won_cnt_in  = 8'd0;
               woff_cnt_in = 10'd0;
               s_low_in    = 1'b1;
            end else begin
               won_cnt_in = (won_cnt_in == 8'd255) ? 8'd255 : won_cnt_in + 8'd1;
            end
         end else begin
            wash_on_in = 1'b0;
            won_cnt_in = 8'd0;
         end
      end else if (wash_off_in) begin
         if (!washer) begin
            if ((woff_cnt_in >= cfg_wash_stop_ff) && req_data.park_switch) begin
               p_low_in    = 1'b0;
               wash_off_in = 1'b0;
               s_low_in    = 1'b0;
            end
            woff_cnt_in = (woff_cnt_in == 10'd1023) ? 10'd1023 : woff_cnt_in + 10'd1;
         end
      end
      wash_prev_in = washer;

      // manual modes; auto selection is last tick's
      if (req_data.ignition) begin
         p_sens_in = 1'b1;
         if (!washer) begin
            p_wash_in = 1'b0;
            s_wash_in = 1'b0;
            if (!wash_off_in && !s_auto_ff) begin
               if (db_in[SW_INT]) begin
                  s_int_in = 1'b1;
                  sweep_in = (sweep_ff == 12'd4095) ? 12'd4095 : sweep_ff + 12'd1;
                  if (sweep_in < {1'b0, cfg_sweep_ff}) begin
                     p_low_in = 1'b1;
                  end else if (sweep_in < period) begin
                     if (req_data.park_switch) p_low_in = 1'b0;
                  end else begin
                     sweep_in = 12'd0;
                  end
               end else begin
                  s_int_in = 1'b0;
                  sweep_in = 12'd0;
               end
               if (db_in[SW_LOW]) begin
                  p_low_in = 1'b1;
                  s_low_in = 1'b1;
               end else begin
                  s_low_in = 1'b0;
                  if (!db_in[SW_INT] && !db_in[SW_HIGH] && req_data.park_switch)
                     p_low_in = 1'b0;
               end
               if (db_in[SW_HIGH]) begin
                  p_low_in  = 1'b1;
                  p_high_in = 1'b1;
                  s_high_in = 1'b1;
               end else begin
                  s_high_in = 1'b0;
                  if (req_data.park_switch) p_high_in = 1'b0;
               end
            end
         end else begin
            p_high_in = 1'b0;
            p_wash_in = 1'b1;
            s_wash_in = 1'b1;
         end
      end else begin
         p_wash_in = 1'b0;
         p_sens_in = 1'b0;
         s_wash_in = 1'b0;
         if (req_data.park_switch) begin
            p_low_in  = 1'b0;
            p_high_in = 1'b0;
         end
         s_int_in  = 1'b0;
         s_low_in  = 1'b0;
         s_high_in = 1'b0;
         sweep_in  = 12'd0;
      end

      // automatic rain-sensor wiping
      if (req_data.ignition) begin
         if (!db_in[SW_INT] && !db_in[SW_LOW] && !db_in[SW_HIGH] &&
             !req_data.remote_off) begin
            s_auto_in = 1'b1;
         end else begin
            s_auto_in = 1'b0;
            settle_in = 6'd0;
         end
         if (s_auto_in) begin
            if (!wash_off_in && !wash_on_in && !washer) begin
               p_rain_in = 1'b1;
               settle_in = (settle_in == 6'd63) ? 6'd63 : settle_in + 6'd1;
               if (settle_in > SETTLE_LIMIT) begin
                  for (int j = 0; j < 2; j++) begin
                     if (rain_req[j]) begin
                        if (rain_cnt_ff[j] >= cfg_rain_confirm_ff) rain_act_in[j] = 1'b1;
                        rain_cnt_in[j] = (rain_cnt_ff[j] == 8'd255) ? 8'd255 :
                                         rain_cnt_ff[j] + 8'd1;
                     end else begin
                        rain_act_in[j] = 1'b0;
                        rain_cnt_in[j] = 8'd0;
                     end
                  end
                  settle_in = SETTLE_HOLD;
               end
               p_park_in = !req_data.park_switch;
               if (rain_act_in[1]) begin
                  p_low_in       = 1'b0;
                  rain_act_in[0] = 1'b0;
               end
               if (rain_act_in[0]) begin
                  p_high_in = 1'b0;
                  p_low_in  = 1'b1;
                  s_low_in  = 1'b1;
               end else begin
                  if (req_data.park_switch) p_low_in = 1'b0;
                  s_low_in = 1'b0;
                  if (rain_act_in[1]) begin
                     p_low_in  = 1'b0;
                     p_high_in = 1'b1;
                     s_high_in = 1'b1;
                  end else begin
                     if (req_data.park_switch) p_high_in = 1'b0;
                     s_high_in = 1'b0;
                  end
               end
            end
         end else begin
            p_rain_in = 1'b0;
         end
      end else begin
         s_auto_in = 1'b0;
         p_rain_in = 1'b0;
         settle_in = 6'd0;
      end

      result.low_drive         = p_low_in;
      result.high_drive        = p_high_in;
      result.washer_drive      = p_wash_in;
      result.cluster_ign       = req_data.ignition | req_data.charge_door;
      result.sensor_power      = p_sens_in;
      result.rain_power        = p_rain_in;
      result.rain_park_signal  = p_park_in;
      result.stat_intermittent = s_int_in;
      result.stat_low          = s_low_in;
      result.stat_high         = s_high_in;
      result.stat_washer       = s_wash_in;
      result.auto_active       = s_auto_in;
   end

   // ---------------------------------------------------------------------
   // Handshake: result register plus one skid entry
   // ---------------------------------------------------------------------
   logic    out_valid_ff;
   logic    skid_valid_ff;
   rsp_type out_data_ff;
   rsp_type skid_data_ff;
   logic    req_accept;
   logic    rsp_take;
   logic    out_free;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid & ~skid_valid_ff;
   assign rsp_take   = out_valid_ff & ~rsp_stall;
   assign out_free   = ~out_valid_ff | rsp_take;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            // skid drains first to keep transaction order
            if (rsp_take) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (req_accept) begin
            if (out_free) out_valid_ff <= 1'b1;
            else          skid_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) out_data_ff <= skid_data_ff;
      end else if (req_accept) begin
         if (out_free) out_data_ff  <= result;
         else          skid_data_ff <= result;
      end
   end

   // tick state advances on every accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         db_ff        <= '0;
         prev_raw_ff  <= '0;
         db_cnt_ff    <= '{default: '0};
         wash_prev_ff <= 1'b0;
         wash_on_ff   <= 1'b0;
         wash_off_ff  <= 1'b0;
         won_cnt_ff   <= '0;
         woff_cnt_ff  <= '0;
         sweep_ff     <= '0;
         p_low_ff     <= 1'b0;
         p_high_ff    <= 1'b0;
         p_wash_ff    <= 1'b0;
         p_sens_ff    <= 1'b0;
         p_rain_ff    <= 1'b0;
         p_park_ff    <= 1'b0;
         s_int_ff     <= 1'b0;
         s_low_ff     <= 1'b0;
         s_high_ff    <= 1'b0;
         s_wash_ff    <= 1'b0;
         s_auto_ff    <= 1'b0;
         settle_ff    <= '0;
         rain_cnt_ff  <= '{default: '0};
         rain_act_ff  <= '0;
      end else if (req_accept) begin
         db_ff        <= db_in;
         prev_raw_ff  <= prev_raw_in;
         db_cnt_ff    <= db_cnt_in;
         wash_prev_ff <= wash_prev_in;
         wash_on_ff   <= wash_on_in;
         wash_off_ff  <= wash_off_in;
         won_cnt_ff   <= won_cnt_in;
         woff_cnt_ff  <= woff_cnt_in;
         sweep_ff     <= sweep_in;
         p_low_ff     <= p_low_in;
         p_high_ff    <= p_high_in;
         p_wash_ff    <= p_wash_in;
         p_sens_ff    <= p_sens_in;
         p_rain_ff    <= p_rain_in;
         p_park_ff    <= p_park_in;
         s_int_ff     <= s_int_in;
         s_low_ff     <= s_low_in;
         s_high_ff    <= s_high_in;
         s_wash_ff    <= s_wash_in;
         s_auto_ff    <= s_auto_in;
         settle_ff    <= settle_in;
         rain_cnt_ff  <= rain_cnt_in;
         rain_act_ff  <= rain_act_in;
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // skid only ever holds an entry behind a full result register
   `WWC_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   // a transaction arriving at a stalled, full result register lands in the skid
   `WWC_ASSERT_NEXT(a_stalled_to_skid, clock, reset,
                    req_accept && out_valid_ff && rsp_stall, skid_valid_ff)
   // ignition off drops washer pump and rain sensor power in that tick's result
   `WWC_ASSERT_NEXT(a_ign_off_pins, clock, reset,
                    req_accept && out_free && !req_data.ignition,
                    rsp_valid && !rsp_data.washer_drive && !rsp_data.rain_power)
   // settle counter is pinned at the hold value once past the limit
   `WWC_ASSERT_NOW(a_settle_bound, clock, reset, 1'b1, settle_ff <= SETTLE_HOLD)
   // high rain request always cancels low
   `WWC_ASSERT_NOW(a_rain_exclusive, clock, reset, 1'b1,
                   !(rain_act_ff[0] && rain_act_ff[1]))

endmodule
